[design/rft_pkg.sv]
package rft_pkg;

	localparam int MAX_LEN_DEF   = 64;
	localparam int MAX_RAILS_DEF = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_RAIL_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 1'd1;

	localparam logic [CFG_DATA_W-1:0] RAIL_COUNT_RST = 5'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} src_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       overflowed;
	} dst_beat_t;

	typedef struct packed {
		logic start;
		logic linear;
		logic advance;
	} walk_ctl_t;

endpackage

[design/rft_ram.sv]
module rft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[design/rft_walk.sv]
module rft_walk import rft_pkg::*; #(
	parameter int MAX_LEN   = MAX_LEN_DEF,
	parameter int MAX_RAILS = MAX_RAILS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  walk_ctl_t                        ctl,
	input  logic [$clog2(MAX_LEN+1)-1:0]     len,
	input  logic [$clog2(MAX_RAILS+1)-1:0]   rails,
	output logic [$clog2(MAX_LEN)-1:0]       pos,
	output logic                             last
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int RW = $clog2(MAX_RAILS+1);
	localparam int SW = $clog2(MAX_LEN + 2*MAX_RAILS + 1);

	logic [RW-1:0] rail_q;
	logic [AW-1:0] pos_q;
	logic          phase_q;
	logic          lin_q;

	logic [SW-1:0] period;
	logic [SW-1:0] step_a;
	logic [SW-1:0] step_b;
	logic [SW-1:0] step;
	logic [SW-1:0] nxt;
	logic [SW-1:0] rail_nxt;
	logic          in_rail;
	logic          rail_end;

	always_comb begin
		period   = (SW'(rails) << 1) - SW'(2);
		step_a   = period - (SW'(rail_q) << 1);
		step_b   = SW'(rail_q) << 1;
		if (lin_q || rails <= RW'(1)) begin
			step = SW'(1);
		end else begin
			step = phase_q ? step_b : step_a;
			if (step == '0) begin
				step = period;
			end
		end
		nxt      = SW'(pos_q) + step;
		in_rail  = nxt < SW'(len);
		rail_nxt = SW'(rail_q) + SW'(1);
		rail_end = lin_q || rail_nxt >= SW'(rails) || rail_nxt >= SW'(len);
		last     = !in_rail && rail_end;
	end

	assign pos = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_q  <= '0;
			pos_q   <= '0;
			phase_q <= 1'b0;
			lin_q   <= 1'b0;
		end else if (ctl.start) begin
			rail_q  <= '0;
			pos_q   <= '0;
			phase_q <= 1'b0;
			lin_q   <= ctl.linear;
		end else if (ctl.advance) begin
			if (in_rail) begin
				pos_q   <= nxt[AW-1:0];
				phase_q <= !phase_q;
			end else if (!rail_end) begin
				rail_q  <= rail_nxt[RW-1:0];
				pos_q   <= rail_nxt[AW-1:0];
				phase_q <= 1'b0;
			end
		end
	end

endmodule

[design/rail_fence_transposer_top.sv]
// loading: bytes load at one per cycle unless stalled; the first output beat follows the
// final byte via a ram read and the output register, in decode mode after a reorder pass
// output: each beat takes a ram read, then the output register, plus any receiver stall;
// decode first reorders every byte into a second ram, a ram read and a ram write per byte
// input stalls from the final byte until the last output beat is registered
// reset: control cleared, rail count 2, encode mode, message ram contents undefined
module rail_fence_transposer_top import rft_pkg::*; #(
	parameter int MAX_LEN   = MAX_LEN_DEF,
	parameter int MAX_RAILS = MAX_RAILS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  src_beat_t             src_beat,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output dst_beat_t             dst_beat,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN+1);
	localparam int RW = $clog2(MAX_RAILS+1);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_PUT   = 2'd2;

	logic [1:0]            state_q;
	logic [LW-1:0]         len_q;
	logic                  ovf_q;
	logic [CFG_DATA_W-1:0] rails_cfg_q;
	logic                  decode_q;
	logic                  pass2_q;
	logic [AW-1:0]         k_q;
	logic                  dst_valid_q;
	dst_beat_t             dst_beat_q;

	logic          src_accept;
	logic          room;
	logic          out_free;
	logic          emit;
	logic          copy;
	logic [RW-1:0] rails_eff;
	walk_ctl_t     walk_ctl;
	logic [AW-1:0] pos;
	logic          last;
	logic [7:0]    msg_rdata;
	logic [7:0]    buf_rdata;

	assign cfg_ready  = 1'b1;
	assign src_stall  = state_q != ST_LOAD;
	assign src_accept = src_valid && !src_stall;
	assign room       = len_q < LW'(MAX_LEN);
	assign out_free   = !dst_valid_q || !dst_stall;
	assign emit       = state_q == ST_PUT && (!decode_q || pass2_q) && out_free;
	assign copy       = state_q == ST_PUT && decode_q && !pass2_q;
	assign dst_valid  = dst_valid_q;
	assign dst_beat   = dst_beat_q;

	always_comb begin
		if (rails_cfg_q == '0) begin
			rails_eff = RW'(1);
		end else if (int'(rails_cfg_q) > MAX_RAILS) begin
			rails_eff = RW'(MAX_RAILS);
		end else begin
			rails_eff = RW'(rails_cfg_q);
		end
	end

	always_comb begin
		walk_ctl.start   = (src_accept && src_beat.end_of_message) || (copy && last);
		walk_ctl.linear  = copy;
		walk_ctl.advance = emit || copy;
	end

	rft_walk #(
		.MAX_LEN   (MAX_LEN),
		.MAX_RAILS (MAX_RAILS)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (walk_ctl),
		.len    (len_q),
		.rails  (rails_eff),
		.pos    (pos),
		.last   (last)
	);

	rft_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LEN)
	) u_msg_ram (
		.clk     (clk),
		.wr_en   (src_accept && room),
		.wr_addr (len_q[AW-1:0]),
		.wr_data (src_beat.data_byte),
		.rd_addr (decode_q ? k_q : pos),
		.rd_data (msg_rdata)
	);

	// decode reorder buffer, filled by rail-major walk, drained in position order
	rft_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LEN)
	) u_buf_ram (
		.clk     (clk),
		.wr_en   (copy),
		.wr_addr (pos),
		.wr_data (msg_rdata),
		.rd_addr (pos),
		.rd_data (buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rails_cfg_q <= RAIL_COUNT_RST;
			decode_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RAIL_COUNT:  rails_cfg_q <= cfg_data;
				REG_DECODE_MODE: decode_q    <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			pass2_q     <= 1'b0;
			k_q         <= '0;
			dst_valid_q <= 1'b0;
		end else begin
			if (dst_valid_q && !dst_stall && !emit) begin
				dst_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (src_accept) begin
						if (room) begin
							len_q <= len_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (src_beat.end_of_message) begin
							state_q <= ST_FETCH;
							pass2_q <= 1'b0;
							k_q     <= '0;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (copy) begin
						k_q     <= k_q + AW'(1);
						state_q <= ST_FETCH;
						if (last) begin
							pass2_q <= 1'b1;
						end
					end else if (emit) begin
						dst_valid_q <= 1'b1;
						if (last) begin
							state_q <= ST_LOAD;
							len_q   <= '0;
							ovf_q   <= 1'b0;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			dst_beat_q.out_byte   <= decode_q ? buf_rdata : msg_rdata;
			dst_beat_q.out_last   <= last;
			dst_beat_q.overflowed <= ovf_q;
		end
	end

endmodule
